// ----- design/pngse_pkg.sv -----
package pngse_pkg;

    localparam int MAX_DIM_DEFAULT      = 16384;
    localparam int BLOCK_BYTES_DEFAULT  = 65535;

    localparam int DIM_W      = 15;
    localparam int PIXEL_W    = 32;
    localparam int BYTE_W     = 8;
    localparam int RAW_W      = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_SWAP   = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_PIXEL = 1'b1
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [PIXEL_W-1:0] pixel;
    } item_t;

    // Frame settings as the back end sees them; raw is the filtered byte count.
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             swap;
        logic [RAW_W-1:0] raw;
        logic [RAW_W-1:0] blocks;
        logic [31:0]      idat_len;
    } frame_cfg_t;

endpackage

// ----- design/png_stored_deflate_encoder_unit.sv -----
// Throughput: one output byte per cycle while requests are queued and m_tready is high;
// a start request gives 43 bytes, a pixel 4 to 10 bytes (filter byte and block header included),
// the last pixel 20 more. The byte sequencer in the back end sets the rate;
// a two-entry queue takes requests meanwhile.
// Reset (aresetn low, synchronous) clears the queue, sequencer and output register,
// and sets width 1, height 1, no byte swap.
module png_stored_deflate_encoder_unit
    import pngse_pkg::*;
#(
    parameter int MAX_DIM            = MAX_DIM_DEFAULT,
    parameter int STORED_BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_W-1:0]    s_tdata,   // pixel[31:0]
    input  logic [0:0]            s_tuser,   // opcode[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [BYTE_W-1:0]     m_tdata,   // out_byte[7:0]
    output logic                  m_tlast,
    output logic [0:0]            m_tuser,   // file_end[0]
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic       item_valid;
    item_t      item;
    logic       item_pop;
    logic       in_frame;
    frame_cfg_t frame_cfg;

    pngse_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    pngse_cfg #(
        .MAX_DIM            (MAX_DIM),
        .STORED_BLOCK_BYTES (STORED_BLOCK_BYTES)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_frame  (in_frame),
        .frame_cfg (frame_cfg)
    );

    pngse_back #(
        .MAX_DIM            (MAX_DIM),
        .STORED_BLOCK_BYTES (STORED_BLOCK_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .frame_cfg  (frame_cfg),
        .in_frame   (in_frame),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ----- design/pngse_front.sv -----
module pngse_front
    import pngse_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [PIXEL_W-1:0] s_tdata,
    input  logic [0:0]         s_tuser,
    output logic               item_valid,
    output item_t              item,
    input  logic               item_pop
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    item_t      incoming;

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign item_valid = (count_reg != 2'd0);
    assign item       = entry_reg[rd_ptr_reg];

    always_comb begin
        incoming.op    = s_tuser[0] ? OP_PIXEL : OP_START;
        incoming.pixel = s_tdata;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= incoming;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (item_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(item_pop);
        end
    end

endmodule

// ----- design/pngse_cfg.sv -----
module pngse_cfg
    import pngse_pkg::*;
#(
    parameter int MAX_DIM            = MAX_DIM_DEFAULT,
    parameter int STORED_BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_frame,
    output frame_cfg_t            frame_cfg
);

    localparam int SHIFT = RAW_W + $clog2(STORED_BLOCK_BYTES);
    localparam logic [32:0] RECIP = 33'((65'd1 << SHIFT) / STORED_BLOCK_BYTES);
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);
    localparam logic [RAW_W-1:0] BLOCK_B = RAW_W'(STORED_BLOCK_BYTES);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             swap_reg;
    logic [DIM_W-1:0] dim_clamped;

    logic [RAW_W-1:0] raw_reg;
    logic [63:0]      prod_reg;
    logic [RAW_W-1:0] raw_d1_reg;
    logic [RAW_W-1:0] quot_reg;
    logic [RAW_W-1:0] raw_d2_reg;
    logic [RAW_W-1:0] quot_d_reg;
    logic [RAW_W-1:0] qb_reg;
    logic [RAW_W-1:0] raw_d3_reg;
    logic [RAW_W-1:0] blocks_reg;
    logic [RAW_W-1:0] raw_d4_reg;
    logic [31:0]      idat_len_reg;

    logic [RAW_W-1:0] remain;
    logic [RAW_W-1:0] remain_fix;
    logic [RAW_W-1:0] quot_fix;
    logic [16:0]      line_bytes;

    always_comb begin
        if (cfg_wdata == '0) begin
            dim_clamped = DIM_W'(1);
        end else if (cfg_wdata > DIM_MAX) begin
            dim_clamped = DIM_MAX;
        end else begin
            dim_clamped = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            swap_reg   <= 1'b0;
        end else if (cfg_wr_en && !in_frame) begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= dim_clamped;
                CFG_HEIGHT: height_reg <= dim_clamped;
                CFG_SWAP:   swap_reg   <= cfg_wdata[0];
                default:    ;
            endcase
        end
    end

    // Block count is the ceiling of raw / block size, by reciprocal multiply
    // and one correction step; the pipeline recomputes it every cycle.
    assign line_bytes = {width_reg, 2'b00} + 17'd1;

    always_comb begin
        remain = raw_d3_reg - qb_reg;
        if (remain >= BLOCK_B) begin
            remain_fix = remain - BLOCK_B;
            quot_fix   = quot_d_reg + RAW_W'(1);
        end else begin
            remain_fix = remain;
            quot_fix   = quot_d_reg;
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg      <= RAW_W'(line_bytes * height_reg);
        prod_reg     <= 64'(raw_reg) * 64'(RECIP);
        raw_d1_reg   <= raw_reg;
        quot_reg     <= RAW_W'(prod_reg >> SHIFT);
        raw_d2_reg   <= raw_d1_reg;
        qb_reg       <= RAW_W'(quot_reg * BLOCK_B);
        quot_d_reg   <= quot_reg;
        raw_d3_reg   <= raw_d2_reg;
        blocks_reg   <= quot_fix + RAW_W'(remain_fix != '0);
        raw_d4_reg   <= raw_d3_reg;
        idat_len_reg <= 32'(raw_d4_reg) + 32'({blocks_reg, 2'b00}) + 32'(blocks_reg) + 32'd6;
    end

    always_comb begin
        frame_cfg.width    = width_reg;
        frame_cfg.height   = height_reg;
        frame_cfg.swap     = swap_reg;
        frame_cfg.raw      = raw_d4_reg;
        frame_cfg.blocks   = blocks_reg;
        frame_cfg.idat_len = idat_len_reg;
    end

endmodule

// ----- design/pngse_back.sv -----
module pngse_back
    import pngse_pkg::*;
#(
    parameter int MAX_DIM            = MAX_DIM_DEFAULT,
    parameter int STORED_BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  item_t             item,
    output logic              item_pop,
    input  frame_cfg_t        frame_cfg,
    output logic              in_frame,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic              m_tlast,
    output logic [0:0]        m_tuser
);

    localparam int COL_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [RAW_W-1:0] BLOCK_B   = RAW_W'(STORED_BLOCK_BYTES);
    localparam logic [16:0]      ADLER_MOD = 17'd65521;
    localparam logic [63:0]      SIGNATURE = 64'h89504E470D0A1A0A;
    localparam logic [31:0]      TAG_IHDR  = 32'h49484452;
    localparam logic [31:0]      TAG_IDAT  = 32'h49444154;
    localparam logic [31:0]      TAG_IEND  = 32'h49454E44;
    localparam logic [31:0]      CRC_POLY  = 32'hEDB88320;
    localparam logic [5:0] HDR_IHDR_TAG = 6'd12;
    localparam logic [5:0] HDR_IDAT_TAG = 6'd37;
    localparam logic [5:0] HDR_LAST     = 6'd42;
    localparam logic [5:0] FIN_IEND_TAG = 6'd12;
    localparam logic [5:0] FIN_LAST     = 6'd19;
    localparam logic [2:0] LAST_RAW     = 3'd4;
    localparam logic [2:0] LAST_HDR     = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_PIX,
        ST_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic [5:0]         idx_reg, idx_next;
    logic [2:0]         k_reg, k_next;
    logic [2:0]         h_reg, h_next;
    logic [PIXEL_W-1:0] pix_reg, pix_next;
    logic [31:0]        crc_reg, crc_next;
    logic [15:0]        adler_lo_reg, adler_lo_next;
    logic [15:0]        adler_hi_reg, adler_hi_next;
    logic [15:0]        block_left_reg, block_left_next;
    logic [RAW_W-1:0]   blocks_left_reg, blocks_left_next;
    logic [RAW_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic               in_frame_reg, in_frame_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0]  m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;
    logic               m_tuser_reg, m_tuser_next;

    logic              out_free;
    logic              emit;
    logic [BYTE_W-1:0] byte_val;
    logic              feed;
    logic              seed;
    logic              last_item;
    logic              file_last;
    logic [BYTE_W-1:0] raw_b;
    logic [15:0]       blk_len;
    logic [16:0]       lo_sum;
    logic [16:0]       hi_sum;
    logic [15:0]       lo_new;
    logic [RAW_W-1:0]  bytes_after;
    logic [1:0]        sel_off;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] sel);
        logic [7:0] r;
        case (sel)
            2'd0:    r = w[31:24];
            2'd1:    r = w[23:16];
            2'd2:    r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = (state_reg != ST_IDLE) && out_free;
    assign sel_off  = idx_reg[1:0] - 2'd1;

    // Raw pixel byte for the current position; position zero is the filter byte.
    always_comb begin
        raw_b = '0;
        if (frame_cfg.swap) begin
            case (k_reg)
                3'd1:    raw_b = pix_reg[23:16];
                3'd2:    raw_b = pix_reg[15:8];
                3'd3:    raw_b = pix_reg[7:0];
                3'd4:    raw_b = (pix_reg[31:24] != 8'd0) ? pix_reg[31:24] : 8'hFF;
                default: raw_b = '0;
            endcase
        end else begin
            case (k_reg)
                3'd1:    raw_b = pix_reg[7:0];
                3'd2:    raw_b = pix_reg[15:8];
                3'd3:    raw_b = pix_reg[23:16];
                3'd4:    raw_b = pix_reg[31:24];
                default: raw_b = '0;
            endcase
        end
    end

    assign blk_len     = (bytes_left_reg > BLOCK_B) ? 16'(BLOCK_B) : bytes_left_reg[15:0];
    assign lo_sum      = {1'b0, adler_lo_reg} + {9'd0, raw_b};
    assign lo_new      = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
    assign hi_sum      = {1'b0, adler_hi_reg} + {1'b0, lo_new};
    assign bytes_after = (bytes_left_reg != '0) ? bytes_left_reg - RAW_W'(1) : bytes_left_reg;

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        k_next           = k_reg;
        h_next           = h_reg;
        pix_next         = pix_reg;
        crc_next         = crc_reg;
        adler_lo_next    = adler_lo_reg;
        adler_hi_next    = adler_hi_reg;
        block_left_next  = block_left_reg;
        blocks_left_next = blocks_left_reg;
        bytes_left_next  = bytes_left_reg;
        col_next         = col_reg;
        in_frame_next    = in_frame_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tlast_next     = m_tlast_reg;
        m_tuser_next     = m_tuser_reg;
        byte_val         = '0;
        feed             = 1'b0;
        seed             = 1'b0;
        last_item        = 1'b0;
        file_last        = 1'b0;
        item_pop         = 1'b0;

        case (state_reg)
            ST_HDR: begin
                if (idx_reg inside {[6'd0:6'd7]}) begin
                    byte_val = SIGNATURE[63 - 8*idx_reg[2:0] -: 8];
                end else if (idx_reg inside {[6'd8:6'd11]}) begin
                    byte_val = word_byte(32'd13, idx_reg[1:0]);
                end else if (idx_reg inside {[6'd12:6'd15]}) begin
                    byte_val = word_byte(TAG_IHDR, idx_reg[1:0]);
                    feed     = 1'b1;
                end else if (idx_reg inside {[6'd16:6'd19]}) begin
                    byte_val = word_byte(32'(frame_cfg.width), idx_reg[1:0]);
                    feed     = 1'b1;
                end else if (idx_reg inside {[6'd20:6'd23]}) begin
                    byte_val = word_byte(32'(frame_cfg.height), idx_reg[1:0]);
                    feed     = 1'b1;
                end else if (idx_reg == 6'd24) begin
                    byte_val = 8'd8;
                    feed     = 1'b1;
                end else if (idx_reg == 6'd25) begin
                    byte_val = 8'd6;
                    feed     = 1'b1;
                end else if (idx_reg inside {[6'd26:6'd28]}) begin
                    byte_val = 8'd0;
                    feed     = 1'b1;
                end else if (idx_reg inside {[6'd29:6'd32]}) begin
                    byte_val = word_byte(~crc_reg, sel_off);
                end else if (idx_reg inside {[6'd33:6'd36]}) begin
                    byte_val = word_byte(frame_cfg.idat_len, sel_off);
                end else if (idx_reg inside {[6'd37:6'd40]}) begin
                    byte_val = word_byte(TAG_IDAT, sel_off);
                    feed     = 1'b1;
                end else if (idx_reg == 6'd41) begin
                    byte_val = 8'h78;
                    feed     = 1'b1;
                end else begin
                    byte_val = 8'h01;
                    feed     = 1'b1;
                end
                seed = (idx_reg == HDR_IHDR_TAG) || (idx_reg == HDR_IDAT_TAG);
                if (emit) begin
                    idx_next = idx_reg + 6'd1;
                    if (idx_reg == HDR_LAST) begin
                        last_item        = 1'b1;
                        adler_lo_next    = 16'd1;
                        adler_hi_next    = 16'd0;
                        block_left_next  = '0;
                        blocks_left_next = frame_cfg.blocks;
                        bytes_left_next  = frame_cfg.raw;
                        col_next         = '0;
                        in_frame_next    = 1'b1;
                    end
                end
            end
            ST_PIX: begin
                feed = 1'b1;
                if (block_left_reg == '0) begin
                    // A stored block opens in front of this byte.
                    case (h_reg)
                        3'd0:    byte_val = {7'd0, blocks_left_reg == RAW_W'(1)};
                        3'd1:    byte_val = blk_len[7:0];
                        3'd2:    byte_val = blk_len[15:8];
                        3'd3:    byte_val = ~blk_len[7:0];
                        default: byte_val = ~blk_len[15:8];
                    endcase
                    if (emit) begin
                        h_next = h_reg + 3'd1;
                        if (h_reg == LAST_HDR) begin
                            h_next          = '0;
                            block_left_next = blk_len;
                            if (blocks_left_reg != '0) begin
                                blocks_left_next = blocks_left_reg - RAW_W'(1);
                            end
                        end
                    end
                end else begin
                    byte_val = raw_b;
                    if (emit) begin
                        adler_lo_next   = lo_new;
                        adler_hi_next   = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD)
                                                                : hi_sum[15:0];
                        block_left_next = block_left_reg - 16'd1;
                        bytes_left_next = bytes_after;
                        k_next          = k_reg + 3'd1;
                        if (k_reg == LAST_RAW) begin
                            if ((DIM_W'(col_reg) + DIM_W'(1)) >= frame_cfg.width) begin
                                col_next = '0;
                            end else begin
                                col_next = col_reg + COL_W'(1);
                            end
                            if (bytes_after == '0) begin
                                state_next = ST_FIN;
                                idx_next   = '0;
                            end else begin
                                last_item = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_FIN: begin
                if (idx_reg inside {[6'd0:6'd3]}) begin
                    byte_val = word_byte({adler_hi_reg, adler_lo_reg}, idx_reg[1:0]);
                    feed     = 1'b1;
                end else if (idx_reg inside {[6'd4:6'd7], [6'd16:6'd19]}) begin
                    byte_val = word_byte(~crc_reg, idx_reg[1:0]);
                end else if (idx_reg inside {[6'd8:6'd11]}) begin
                    byte_val = 8'd0;
                end else begin
                    byte_val = word_byte(TAG_IEND, idx_reg[1:0]);
                    feed     = 1'b1;
                end
                seed = (idx_reg == FIN_IEND_TAG);
                if (emit) begin
                    idx_next = idx_reg + 6'd1;
                    if (idx_reg == FIN_LAST) begin
                        last_item     = 1'b1;
                        file_last     = 1'b1;
                        in_frame_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = byte_val;
            m_tlast_next  = last_item;
            m_tuser_next  = file_last;
            if (feed) begin
                crc_next = crc_byte(seed ? 32'hFFFFFFFF : crc_reg, byte_val);
            end
        end

        if (emit && last_item) begin
            state_next = ST_IDLE;
        end

        // The next request is taken in the cycle the current one sends its last byte.
        if ((state_reg == ST_IDLE || (emit && last_item)) && item_valid) begin
            item_pop = 1'b1;
            if (item.op == OP_START) begin
                state_next = ST_HDR;
                idx_next   = '0;
            end else if (in_frame_next) begin
                state_next = ST_PIX;
                pix_next   = item.pixel;
                k_next     = (col_next == '0) ? 3'd0 : 3'd1;
                h_next     = '0;
            end else begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg     <= pix_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            k_reg           <= '0;
            h_reg           <= '0;
            crc_reg         <= 32'hFFFFFFFF;
            adler_lo_reg    <= 16'd1;
            adler_hi_reg    <= 16'd0;
            block_left_reg  <= '0;
            blocks_left_reg <= '0;
            bytes_left_reg  <= '0;
            col_reg         <= '0;
            in_frame_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            k_reg           <= k_next;
            h_reg           <= h_next;
            crc_reg         <= crc_next;
            adler_lo_reg    <= adler_lo_next;
            adler_hi_reg    <= adler_hi_next;
            block_left_reg  <= block_left_next;
            blocks_left_reg <= blocks_left_next;
            bytes_left_reg  <= bytes_left_next;
            col_reg         <= col_next;
            in_frame_reg    <= in_frame_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    assign in_frame = in_frame_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- design/pngse_checker.sv -----
module pngse_checker
    import pngse_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [BYTE_W-1:0] m_tdata,
    input logic              m_tlast,
    input logic [0:0]        m_tuser
);

    // The final byte of a file always closes the request that produced it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("file end without request end");

    // The last byte of the file is the last byte of the constant IEND CRC.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 8'h82)
        else $error("file end byte is not the IEND CRC tail");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

endmodule

bind png_stored_deflate_encoder_unit pngse_checker u_pngse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
